// ----- rtl/wpsf_pkg.sv -----
package wpsf_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int CHANNEL_W    = 5;
    localparam int TICK_OUT_W   = 11;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int EXCESS_W     = 21;
    localparam int WINDOW_CELLS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] BASELINE_RESET  = 16'd32800;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd29;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [CHANNEL_W-1:0] channel;
        logic                 last_sample;
    } t_in;

    typedef struct packed {
        logic                  pulse_valid;
        logic [TICK_OUT_W-1:0] pulse_tick;
        logic [CHANNEL_W-1:0]  pulse_channel;
        logic                  waveform_done;
    } t_out;

    typedef struct packed {
        logic first;
        logic ge1;
        logic ge2;
        logic ge3;
    } t_tick_flags;

endpackage

// ----- rtl/wpsf_tap.sv -----
module wpsf_tap #(
    parameter int SW  = 12,
    parameter int PSW = 15
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [SW-1:0]  i_sample,
    input  logic [PSW-1:0] i_psum,
    output logic [SW-1:0]  o_sample,
    output logic [PSW-1:0] o_psum
);

    logic [SW-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_adv) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_psum   = i_psum + PSW'(r_sample);

endmodule

// ----- rtl/wpsf_clean.sv -----
module wpsf_clean #(
    parameter int SW = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  wpsf_pkg::t_tick_flags i_flags,
    input  logic [SW-1:0]         i_sample,
    input  logic [SW-1:0]         i_prev_sample,
    output logic                  o_check
);

    localparam int DW = SW + 1;

    logic signed [DW-1:0] r_dw0, r_dw1, r_dw2;
    logic                 r_open;
    logic [1:0]           r_cand;

    logic signed [DW-1:0] raw, prev0, prev, cur, f;
    logic signed [DW:0]   pair_sum;
    logic                 cancel, open_base, n_open, cand, f_pos;
    logic [1:0]           cand_base;

    always_comb begin
        prev0     = i_flags.first ? '0 : r_dw0;
        raw       = $signed({1'b0, i_sample}) - $signed({1'b0, i_prev_sample});
        pair_sum  = $signed({raw[DW-1], raw}) + $signed({prev0[DW-1], prev0});
        cancel    = i_flags.ge1 && (pair_sum == '0);
        cur       = (i_flags.ge1 && !cancel) ? raw : '0;
        prev      = cancel ? '0 : prev0;
        // isolated nonzero between two zeros
        if (i_flags.ge3 && r_dw2 == '0 && r_dw1 != '0 && prev == '0) begin
            f = '0;
        end else begin
            f = r_dw1;
        end
        f_pos     = !f[DW-1] && (f != '0);
        open_base = i_flags.first ? 1'b0 : r_open;
        cand_base = i_flags.first ? 2'b00 : r_cand;
        n_open    = open_base;
        cand      = 1'b0;
        if (i_flags.ge2) begin
            if (!open_base && f_pos) begin
                n_open = 1'b1;
                cand   = 1'b1;
            end else if (open_base && !f_pos) begin
                n_open = 1'b0;
            end
        end
    end

    assign o_check = cand_base[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw0  <= '0;
            r_dw1  <= '0;
            r_dw2  <= '0;
            r_open <= 1'b0;
            r_cand <= 2'b00;
        end else if (i_adv) begin
            r_dw0  <= cur;
            r_dw1  <= prev;
            r_dw2  <= f;
            r_open <= n_open;
            r_cand <= {cand_base[0], cand};
        end
    end

endmodule

// ----- rtl/waveform_pulse_start_finder_core.sv -----
// waveform pulse start finder, one channel
// input channel: i_in_valid / o_in_ready carry one adc sample request per cycle
//   unless a held result stalls it, with its channel tag and a last-sample mark;
//   tick 0 is the first sample after reset, a last mark or MAX_TICKS samples
// output channel: o_out_valid / i_out_ready, exactly one result per sample;
//   a pulse start at tick i is reported on the result of sample i+4
// config channel: i_cfg_valid / o_cfg_ready, index 0 baseline, index 1
//   threshold, both q4; always ready, write only while idle
// the result of an accepted sample is registered in the output register
// throughput: one sample per cycle unless the output stalls; a four-cell sample
//   chain with a running five-sample sum and a difference cleaning stage, all
//   updated in the accept cycle
// a stalled receiver holds the result register; a new sample is still taken
//   in the cycle the held result is taken
// reset (synchronous, active low) clears the windows, the tick counter,
//   the open pulse and the output valid flag and loads default config
module waveform_pulse_start_finder_core #(
    parameter int MAX_TICKS   = 2048,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  wpsf_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output wpsf_pkg::t_out                     o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wpsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpsf_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int SW    = (SAMPLE_BITS < wpsf_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                              : wpsf_pkg::SAMPLE_W;
    localparam int PSW   = SW + 3;
    localparam int TW    = $clog2(MAX_TICKS);
    localparam int NC    = wpsf_pkg::WINDOW_CELLS;
    localparam int EW    = wpsf_pkg::EXCESS_W;
    localparam logic [TW-1:0] TICK_LAST = TW'(MAX_TICKS - 1);

    logic [wpsf_pkg::CFG_W-1:0]     r_baseline, r_threshold;
    logic [TW-1:0]                  r_tick, n_tick;
    logic [wpsf_pkg::CHANNEL_W-1:0] r_chan, chan_now;
    logic                           r_out_valid;
    wpsf_pkg::t_out                 r_out, n_out;

    logic                  adv, check, ge4, pulse;
    logic [SW-1:0]         s_now;
    wpsf_pkg::t_tick_flags flags;
    logic [SW-1:0]         tap_sample [NC+1];
    logic [PSW-1:0]        tap_psum   [NC+1];
    logic signed [EW-1:0]  excess;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign adv         = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign s_now       = i_in.sample[SW-1:0];
    assign flags.first = (r_tick == '0);
    assign flags.ge1   = (r_tick >= TW'(1));
    assign flags.ge2   = (r_tick >= TW'(2));
    assign flags.ge3   = (r_tick >= TW'(3));
    assign ge4         = (r_tick >= TW'(4));
    assign chan_now    = flags.first ? i_in.channel : r_chan;

    assign tap_sample[0] = s_now;
    assign tap_psum[0]   = PSW'(s_now);

    for (genvar g = 0; g < NC; g++) begin : g_tap
        wpsf_tap #(
            .SW  (SW),
            .PSW (PSW)
        ) u_tap (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_sample (tap_sample[g]),
            .i_psum   (tap_psum[g]),
            .o_sample (tap_sample[g+1]),
            .o_psum   (tap_psum[g+1])
        );
    end

    wpsf_clean #(
        .SW (SW)
    ) u_clean (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_flags       (flags),
        .i_sample      (s_now),
        .i_prev_sample (tap_sample[1]),
        .o_check       (check)
    );

    // 16 * five-sample sum minus five baselines
    assign excess = $signed(EW'({tap_psum[NC], 4'b0000}))
                  - $signed(EW'({r_baseline, 2'b00}) + EW'(r_baseline));
    assign pulse  = check && ge4 && (excess > $signed(EW'(r_threshold)));

    always_comb begin
        n_out.pulse_valid   = pulse;
        n_out.pulse_tick    = pulse ? wpsf_pkg::TICK_OUT_W'(r_tick - TW'(4)) : '0;
        n_out.pulse_channel = chan_now;
        n_out.waveform_done = i_in.last_sample;
        if (i_in.last_sample || r_tick == TICK_LAST) begin
            n_tick = '0;
        end else begin
            n_tick = r_tick + TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= wpsf_pkg::BASELINE_RESET;
            r_threshold <= wpsf_pkg::THRESHOLD_RESET;
            r_tick      <= '0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wpsf_pkg::CFG_BASELINE:  r_baseline  <= i_cfg_data;
                    wpsf_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (adv) begin
                r_tick      <= n_tick;
                r_chan      <= chan_now;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_in.last_sample |=> r_tick == '0)
        else $error("tick counter not restarted after last sample");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("accepted request produced no result");

    a_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.pulse_valid |-> r_out.pulse_tick == '0)
        else $error("pulse tick set without pulse");

    a_chan_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && flags.first |=> r_chan == $past(i_in.channel))
        else $error("channel tag not latched on first tick");

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int MAX_TICKS = 2048;
    localparam int IDLE_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    wpsf_pkg::t_in in_data = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    wpsf_pkg::t_out o_out;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [wpsf_pkg::CFG_IDX_W-1:0] cfg_index = wpsf_pkg::CFG_BASELINE;
    logic [wpsf_pkg::CFG_W-1:0] cfg_data = '0;

    wpsf_pkg::t_in pending_samples[$];
    wpsf_pkg::t_out expected_results[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cnt = 0;
    logic [15:0] stall_pat = '1;
    int idle_cycles = 0;

    // predictor state
    logic [wpsf_pkg::CFG_W-1:0] cfg_baseline;
    logic [wpsf_pkg::CFG_W-1:0] cfg_threshold;
    logic [wpsf_pkg::SAMPLE_W-1:0] samp_win[5];
    logic signed [12:0] diff_win[3];
    logic [wpsf_pkg::TICK_OUT_W-1:0] tick_cnt;
    logic pulse_open;
    logic [wpsf_pkg::CHANNEL_W-1:0] chan_tag;
    logic [1:0] cand_pipe;

    waveform_pulse_start_finder_core #(
        .MAX_TICKS(MAX_TICKS),
        .SAMPLE_BITS(wpsf_pkg::SAMPLE_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in(in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out(o_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic wpsf_pkg::t_out find_pulse_start(input wpsf_pkg::t_in smp);
        wpsf_pkg::t_out res;
        logic [wpsf_pkg::TICK_OUT_W-1:0] t;
        logic [wpsf_pkg::SAMPLE_W-1:0] s;
        logic signed [12:0] cur;
        logic signed [12:0] prev;
        logic signed [12:0] f;
        logic cand;
        logic check;
        logic hit;
        longint total;
        t = tick_cnt;
        s = smp.sample;
        cand = 1'b0;
        hit = 1'b0;
        cur = '0;
        if (t == 0) begin
            chan_tag = smp.channel;
            pulse_open = 1'b0;
            cand_pipe = '0;
        end
        for (int k = 4; k > 0; k--) begin
            samp_win[k] = samp_win[k-1];
        end
        samp_win[0] = s;
        // raw difference, cancelled against the previous one
        prev = (t == 0) ? 13'sd0 : diff_win[0];
        if (t >= 1) begin
            cur = $signed({1'b0, s}) - $signed({1'b0, samp_win[1]});
            if (cur == -prev) begin
                cur = '0;
                prev = '0;
            end
        end
        // isolated nonzero between two zeros
        if (t >= 3 && diff_win[2] == 0 && diff_win[1] != 0 && prev == 0) begin
            diff_win[1] = '0;
        end
        if (t >= 2) begin
            f = diff_win[1];
            if (!pulse_open && f > 0) begin
                pulse_open = 1'b1;
                cand = 1'b1;
            end else if (pulse_open && f <= 0) begin
                pulse_open = 1'b0;
            end
        end
        diff_win[2] = diff_win[1];
        diff_win[1] = prev;
        diff_win[0] = cur;
        check = cand_pipe[1];
        cand_pipe = {cand_pipe[0], cand};
        if (check && t >= 4) begin
            total = 0;
            for (int k = 0; k < 5; k++) begin
                total = total + longint'(samp_win[k]);
            end
            total = total * 16 - 5 * longint'(cfg_baseline);
            hit = total > longint'(cfg_threshold);
        end
        res.pulse_valid = hit;
        res.pulse_tick = hit ? t - 11'd4 : '0;
        res.pulse_channel = chan_tag;
        res.waveform_done = smp.last_sample;
        if (smp.last_sample || int'(t) + 1 >= MAX_TICKS) begin
            tick_cnt = '0;
        end else begin
            tick_cnt = t + 1'b1;
        end
        return res;
    endfunction

    function automatic void report_field(input string name, input logic [10:0] want,
                                         input logic [10:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            cfg_baseline = wpsf_pkg::BASELINE_RESET;
            cfg_threshold = wpsf_pkg::THRESHOLD_RESET;
            foreach (samp_win[k]) samp_win[k] = '0;
            foreach (diff_win[k]) diff_win[k] = '0;
            tick_cnt = '0;
            pulse_open = 1'b0;
            chan_tag = '0;
            cand_pipe = '0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.insert(expected_results.size(), find_pulse_start(in_data));
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= pending_samples.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(100, 250);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = $urandom_range(0, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        wpsf_pkg::t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: no result expected, got valid %0d tick %0d channel %0d done %0d",
                             $time, o_out.pulse_valid, o_out.pulse_tick,
                             o_out.pulse_channel, o_out.waveform_done);
                end else begin
                    want = expected_results.pop_front();
                    report_field("pulse_valid", 11'(want.pulse_valid), 11'(o_out.pulse_valid));
                    report_field("pulse_tick", want.pulse_tick, o_out.pulse_tick);
                    report_field("pulse_channel", 11'(want.pulse_channel),
                                 11'(o_out.pulse_channel));
                    report_field("waveform_done", 11'(want.waveform_done),
                                 11'(o_out.waveform_done));
                end
            end
            if (stall_cnt == 0) begin
                stall_cnt = 64;
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'hEEEE;
                    default: stall_pat = 16'($urandom) | 16'($urandom);
                endcase
            end else begin
                stall_cnt--;
            end
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            out_ready <= stall_pat[0];
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_sample(input int s, input logic [wpsf_pkg::CHANNEL_W-1:0] ch,
                              input logic last);
        wpsf_pkg::t_in req;
        req.sample = wpsf_pkg::SAMPLE_W'(s);
        req.channel = ch;
        req.last_sample = last;
        pending_samples.insert(pending_samples.size(), req);
    endtask

    task automatic write_reg(input logic [wpsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wpsf_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            wpsf_pkg::CFG_BASELINE: cfg_baseline = data;
            wpsf_pkg::CFG_THRESHOLD: cfg_threshold = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // baseline with small noise, pulses with a short rise and a slow decay
    task automatic add_waveform(input int len, input int level, input int pulses,
                                input int forced_at);
        int wave[];
        int start;
        int amp;
        int rise;
        int idx;
        int v;
        int noise;
        logic [wpsf_pkg::CHANNEL_W-1:0] ch;
        wave = new[len];
        ch = wpsf_pkg::CHANNEL_W'($urandom_range(0, 31));
        for (int i = 0; i < len; i++) begin
            noise = int'($urandom_range(0, 9));
            wave[i] = level + ((noise > 5) ? noise - 7 : 0);
        end
        for (int p = 0; p <= pulses; p++) begin
            if (p == pulses && forced_at < 0) continue;
            start = (p == pulses) ? forced_at : int'($urandom_range(0, len - 1));
            amp = $urandom_range(3, 1500);
            rise = $urandom_range(1, 4);
            for (int j = 0; j < rise + 12; j++) begin
                idx = start + j;
                if (idx < len) begin
                    wave[idx] += (j < rise) ? amp * (j + 1) / rise : amp >> ((j - rise + 2) / 2);
                end
            end
        end
        for (int i = 0; i < len; i++) begin
            v = (wave[i] < 0) ? 0 : ((wave[i] > 4095) ? 4095 : wave[i]);
            add_sample(v, (i == 0 || $urandom_range(0, 3) != 0) ? ch
                       : wpsf_pkg::CHANNEL_W'($urandom_range(0, 31)), i == len - 1);
        end
    endtask

    task automatic run_phase(input logic [wpsf_pkg::CFG_W-1:0] baseline,
                             input logic [wpsf_pkg::CFG_W-1:0] threshold,
                             input int count, input int level, input bit overlong);
        int target;
        int len;
        int lvl;
        write_reg(wpsf_pkg::CFG_BASELINE, baseline);
        write_reg(wpsf_pkg::CFG_THRESHOLD, threshold);
        if (overlong) begin
            add_waveform(MAX_TICKS + 40, level, 40, MAX_TICKS - 3);
        end
        target = pending_samples.size() + count;
        while (pending_samples.size() < target) begin
            lvl = (level < 0) ? int'($urandom_range(0, 4095)) : level;
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 10)) begin
                        add_sample($urandom_range(0, 4095),
                                   wpsf_pkg::CHANNEL_W'($urandom_range(0, 31)),
                                   $urandom_range(0, 3) == 0);
                    end
                end
                2: begin
                    len = $urandom_range(41, 200);
                    add_waveform(len, lvl, len / 10 + 1, -1);
                end
                default: begin
                    len = $urandom_range(2, 40);
                    add_waveform(len, lvl, len / 10 + $urandom_range(0, 2),
                                 ($urandom_range(0, 2) == 0) ? len - int'($urandom_range(1, 4))
                                 : -1);
                end
            endcase
        end
        wait_idle();
    endtask

    initial begin
        int wave_a[12] = '{2050, 2050, 2051, 2050, 2050, 2052, 2052, 2060, 2100, 2200, 2300, 2300};
        int wave_b[6] = '{0, 4095, 0, 4095, 2000, 3000};
        logic [wpsf_pkg::CFG_W-1:0] rnd_base;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cancelling pair, isolated step, a real start, then a late edge
        foreach (wave_a[i]) add_sample(wave_a[i], 5'd31, i == 11);
        foreach (wave_b[i]) add_sample(wave_b[i], 5'd0, i == 5);
        add_sample(4095, 5'd21, 1'b1);
        add_sample(0, 5'd10, 1'b1);
        wait_idle();

        run_phase(wpsf_pkg::BASELINE_RESET, wpsf_pkg::THRESHOLD_RESET, 120, 2050, 1'b0);
        run_phase('0, '0, 100, -1, 1'b0);
        run_phase('1, '1, 80, 4095, 1'b0);
        run_phase('0, '1, 80, -1, 1'b0);
        run_phase('1, '0, 80, 4095, 1'b0);
        rnd_base = wpsf_pkg::CFG_W'($urandom_range(0, 65535));
        run_phase(rnd_base, wpsf_pkg::CFG_W'($urandom_range(0, 400)), 120,
                  (rnd_base >> 4) > 4095 ? 4095 : int'(rnd_base >> 4), 1'b0);
        run_phase(wpsf_pkg::BASELINE_RESET, wpsf_pkg::THRESHOLD_RESET, 80, 2050, 1'b0);
        run_phase(wpsf_pkg::CFG_W'($urandom_range(0, 65535)),
                  wpsf_pkg::CFG_W'($urandom_range(0, 65535)), 120, -1, 1'b0);

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
